[src/iq4_pkg.sv]
// Shared types and constants for the IQ4_NL by Q8 row dot-product block.
package iq4_pkg;

    // Dot-product lane geometry.
    localparam int LANES      = 4;
    localparam int LANE_ELEMS = 8;
    localparam int CODE_W     = 4;
    localparam int PROD_W     = 16;
    localparam int LANE_SUM_W = 19;
    localparam int DOT_W      = 21;

    // Configuration register indexes.
    typedef enum logic {
        CFG_CODEBOOK_LOW  = 1'b0,
        CFG_CODEBOOK_HIGH = 1'b1
    } t_cfg_idx;

    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

    // Request from the control logic to the floating-point unit.
    typedef struct packed {
        logic start;
        logic last;
        logic out_busy;
    } t_fpu_cmd;

    // Status and result from the floating-point unit.
    typedef struct packed {
        logic        busy;
        logic        emit;
        logic [31:0] sum;
    } t_fpu_rsp;

endpackage

[src/iq4_lane.sv]
// One dot-product lane: decodes eight codes and sums eight products.
module iq4_lane (
    input  logic                                  i_clk,
    input  logic                                  i_load,
    input  logic                                  i_high_nib,
    input  logic [63:0]                           i_codes,
    input  logic [63:0]                           i_acts,
    input  logic [127:0]                          i_codebook,
    output logic signed [iq4_pkg::LANE_SUM_W-1:0] o_sum
);

    logic signed [iq4_pkg::LANE_SUM_W-1:0] r_sum;
    logic signed [iq4_pkg::LANE_SUM_W-1:0] n_sum;

    // Look up each code in the codebook and accumulate the products.
    always_comb begin
        logic [iq4_pkg::CODE_W-1:0]     nib;
        logic signed [7:0]              w;
        logic signed [7:0]              a;
        logic signed [iq4_pkg::PROD_W-1:0] p;
        n_sum = '0;
        for (int e = 0; e < iq4_pkg::LANE_ELEMS; e++) begin
            nib   = i_high_nib ? i_codes[8*e+4 +: 4] : i_codes[8*e +: 4];
            w     = i_codebook[{nib, 3'b000} +: 8];
            a     = i_acts[8*e +: 8];
            p     = w * a;
            n_sum = n_sum + iq4_pkg::LANE_SUM_W'(p);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

[src/iq4_fpu.sv]
// Floating-point unit: scale product, dot scaling and fused accumulation.
module iq4_fpu (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  iq4_pkg::t_fpu_cmd                i_cmd,
    input  logic [15:0]                      i_weight_scale,
    input  logic [31:0]                      i_act_scale,
    input  logic signed [iq4_pkg::DOT_W-1:0] i_dot,
    output iq4_pkg::t_fpu_rsp                o_rsp
);

    localparam int DOT_SIGN_W = iq4_pkg::DOT_W;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_SMUL = 9'b000000010,
        S_SLZC = 9'b000000100,
        S_SRND = 9'b000001000,
        S_TMUL = 9'b000010000,
        S_ALGN = 9'b000100000,
        S_ADD  = 9'b001000000,
        S_LZC  = 9'b010000000,
        S_RND  = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    // Position of the leading one of a wide magnitude.
    function automatic logic [6:0] f_lzc(input logic [95:0] m);
        logic [6:0] p;
        p = '0;
        for (int i = 0; i < 96; i++) begin
            if (m[i]) begin
                p = 7'(i);
            end
        end
        return p;
    endfunction

    // Round s * m * 2^e to single precision, nearest even, with subnormals.
    function automatic logic [31:0] f_round(input logic s, input logic [95:0] m,
                                            input logic signed [11:0] e,
                                            input logic [6:0] p);
        logic signed [11:0] sh_a;
        logic signed [11:0] sh_b;
        logic signed [11:0] sh;
        logic signed [11:0] neg;
        logic signed [11:0] eo;
        logic signed [11:0] field;
        logic [191:0]       wide;
        logic [95:0]        kept;
        logic               rb;
        logic               st;
        logic [24:0]        r;
        logic [31:0]        res;
        sh_a = $signed({5'b0, p}) - 12'sd23;
        sh_b = -12'sd149 - e;
        sh   = (sh_a > sh_b) ? sh_a : sh_b;
        neg  = -sh;
        wide = '0;
        if (sh <= 12'sd0) begin
            kept = m << neg[4:0];
            rb   = 1'b0;
            st   = 1'b0;
        end else begin
            wide = {m, 96'b0} >> sh[6:0];
            kept = wide[191:96];
            rb   = wide[95];
            st   = |wide[94:0];
        end
        r  = kept[24:0] + 25'(rb & (st | kept[0]));
        eo = e + sh;
        if (r[24]) begin
            r  = r >> 1;
            eo = eo + 12'sd1;
        end
        field = r[23] ? (eo + 12'sd150) : 12'sd0;
        if (field >= 12'sd255) begin
            res = {s, 8'hFF, 23'b0};
        end else begin
            res = {s, field[7:0], r[22:0]};
        end
        return res;
    endfunction

    // Captured item operands.
    logic [15:0]        r_ws;
    logic [31:0]        r_xs;
    logic               r_last;
    // Shared rounding operand.
    logic [95:0]        r_m;
    logic signed [11:0] r_e;
    logic               r_s;
    logic [6:0]         r_p;
    // Scale product.
    logic               r_sc_nan;
    logic               r_sc_inf;
    logic [31:0]        r_sc_bits;
    // Term and accumulator operands.
    logic [43:0]        r_t_m;
    logic signed [11:0] r_t_e;
    logic               r_t_s;
    logic [23:0]        r_a_m;
    logic signed [11:0] r_a_e;
    logic               r_a_s;
    logic               r_a_zero;
    logic               r_fixed;
    logic [31:0]        r_fixed_bits;
    // Alignment.
    logic [43:0]        r_hi_m;
    logic [43:0]        r_lo_m;
    logic               r_hi_s;
    logic               r_lo_s;
    logic [5:0]         r_sh;
    logic [11:0]        r_rs;
    logic signed [11:0] r_ec;
    // Row accumulator.
    logic [31:0]        r_acc;

    logic [31:0]        w_round;
    logic               w_hold;

    assign w_round = f_round(r_s, r_m, r_e, r_p);
    assign w_hold  = r_last && i_cmd.out_busy;

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_cmd.start) n_state = S_SMUL;
            S_SMUL: n_state = S_SLZC;
            S_SLZC: n_state = S_SRND;
            S_SRND: n_state = S_TMUL;
            S_TMUL: n_state = S_ALGN;
            S_ALGN: n_state = S_ADD;
            S_ADD:  n_state = S_LZC;
            S_LZC:  n_state = S_RND;
            S_RND:  if (!w_hold) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Row accumulator: updated once per item, cleared after the last block.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (r_state == S_RND && !w_hold) begin
            r_acc <= r_last ? 32'h0 : (r_fixed ? r_fixed_bits : w_round);
        end
    end

    // Datapath steps.
    always_ff @(posedge i_clk) begin
        logic               hs, xsg;
        logic [4:0]         he;
        logic [9:0]         hf;
        logic [7:0]         xe;
        logic [22:0]        xf;
        logic [10:0]        hm;
        logic [23:0]        xm;
        logic signed [11:0] hexp, xexp;
        logic               h_nan, h_inf, h_zero, x_nan, x_inf, x_zero;
        logic [7:0]         sf, af;
        logic [23:0]        ms;
        logic signed [11:0] es;
        logic               s_inf, s_zero, d_neg, d_zero, t_s;
        logic [19:0]        d_mag;
        logic [DOT_SIGN_W-1:0] d_abs;
        logic               a_nan, a_inf, a_zero;
        logic               hi_acc;
        logic signed [11:0] d;
        logic [5:0]         sh;
        logic [95:0]        hi_v, lo_v, sum;
        logic [107:0]       lo_t;
        logic               sum_s;
        hs = 1'b0; xsg = 1'b0; he = '0; hf = '0; xe = '0; xf = '0; hm = '0; xm = '0;
        hexp = '0; xexp = '0; h_nan = 1'b0; h_inf = 1'b0; h_zero = 1'b0;
        x_nan = 1'b0; x_inf = 1'b0; x_zero = 1'b0; sf = '0; af = '0; ms = '0; es = '0;
        s_inf = 1'b0; s_zero = 1'b0; d_neg = 1'b0; d_zero = 1'b0; t_s = 1'b0;
        d_mag = '0; d_abs = '0; a_nan = 1'b0; a_inf = 1'b0; a_zero = 1'b0;
        hi_acc = 1'b0; d = '0; sh = '0; hi_v = '0; lo_v = '0; sum = '0; lo_t = '0;
        sum_s = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd.start) begin
                    r_ws   <= i_weight_scale;
                    r_xs   <= i_act_scale;
                    r_last <= i_cmd.last;
                end
            end
            // Exact product of the half and single scales.
            S_SMUL: begin
                hs = r_ws[15]; he = r_ws[14:10]; hf = r_ws[9:0];
                xsg = r_xs[31]; xe = r_xs[30:23]; xf = r_xs[22:0];
                hm   = (he == 5'd0) ? {1'b0, hf} : {1'b1, hf};
                hexp = (he == 5'd0) ? -12'sd24 : ($signed({7'b0, he}) - 12'sd25);
                xm   = (xe == 8'd0) ? {1'b0, xf} : {1'b1, xf};
                xexp = (xe == 8'd0) ? -12'sd149 : ($signed({4'b0, xe}) - 12'sd150);
                h_nan  = (he == 5'h1F) && (hf != '0);
                h_inf  = (he == 5'h1F) && (hf == '0);
                h_zero = (he == 5'd0) && (hf == '0);
                x_nan  = (xe == 8'hFF) && (xf != '0);
                x_inf  = (xe == 8'hFF) && (xf == '0);
                x_zero = (xe == 8'd0) && (xf == '0);
                r_sc_nan <= h_nan | x_nan | (h_inf & x_zero) | (x_inf & h_zero);
                r_sc_inf <= h_inf | x_inf;
                r_s <= hs ^ xsg;
                r_m <= 96'(hm * xm);
                r_e <= hexp + xexp;
            end
            S_SLZC, S_LZC: begin
                r_p <= f_lzc(r_m);
            end
            // Scale rounded once to single precision.
            S_SRND: begin
                if (r_sc_nan) begin
                    r_sc_bits <= iq4_pkg::CANON_NAN;
                end else if (r_sc_inf) begin
                    r_sc_bits <= {r_s, 8'hFF, 23'b0};
                end else begin
                    r_sc_bits <= w_round;
                end
            end
            // Exact term dot * scale, accumulator decode and special cases.
            S_TMUL: begin
                sf     = r_sc_bits[30:23];
                ms     = (sf == 8'd0) ? {1'b0, r_sc_bits[22:0]} : {1'b1, r_sc_bits[22:0]};
                es     = (sf == 8'd0) ? -12'sd149 : ($signed({4'b0, sf}) - 12'sd150);
                s_inf  = (sf == 8'hFF) && !r_sc_nan;
                s_zero = (sf == 8'd0) && (r_sc_bits[22:0] == '0);
                d_neg  = i_dot[iq4_pkg::DOT_W-1];
                d_zero = (i_dot == '0);
                d_abs  = d_neg ? DOT_SIGN_W'(-i_dot) : DOT_SIGN_W'(i_dot);
                d_mag  = d_abs[19:0];
                t_s    = r_sc_bits[31] ^ d_neg;
                af     = r_acc[30:23];
                a_nan  = (af == 8'hFF) && (r_acc[22:0] != '0);
                a_inf  = (af == 8'hFF) && (r_acc[22:0] == '0);
                a_zero = (af == 8'd0) && (r_acc[22:0] == '0);
                r_t_m    <= d_mag * ms;
                r_t_e    <= es;
                r_t_s    <= t_s;
                r_a_m    <= (af == 8'd0) ? {1'b0, r_acc[22:0]} : {1'b1, r_acc[22:0]};
                r_a_e    <= (af == 8'd0) ? -12'sd149 : ($signed({4'b0, af}) - 12'sd150);
                r_a_s    <= r_acc[31];
                r_a_zero <= a_zero;
                if (r_sc_nan || a_nan || (s_inf && d_zero) ||
                    (s_inf && a_inf && (t_s != r_acc[31]))) begin
                    r_fixed      <= 1'b1;
                    r_fixed_bits <= iq4_pkg::CANON_NAN;
                end else if (s_inf) begin
                    r_fixed      <= 1'b1;
                    r_fixed_bits <= {t_s, 8'hFF, 23'b0};
                end else if (a_inf) begin
                    r_fixed      <= 1'b1;
                    r_fixed_bits <= r_acc;
                end else if (d_zero || s_zero) begin
                    r_fixed      <= 1'b1;
                    r_fixed_bits <= a_zero ? {t_s & r_acc[31], 31'b0} : r_acc;
                end else begin
                    r_fixed      <= 1'b0;
                    r_fixed_bits <= r_acc;
                end
            end
            // Larger exponent on top, left shift bounded so the smaller side keeps a sticky.
            S_ALGN: begin
                hi_acc = !r_a_zero && (r_a_e > r_t_e);
                d      = hi_acc ? (r_a_e - r_t_e) : (r_t_e - r_a_e);
                sh     = (d > 12'sd50) ? 6'd50 : d[5:0];
                r_hi_m <= hi_acc ? 44'(r_a_m) : r_t_m;
                r_lo_m <= hi_acc ? r_t_m : 44'(r_a_m);
                r_hi_s <= hi_acc ? r_a_s : r_t_s;
                r_lo_s <= hi_acc ? r_t_s : r_a_s;
                r_sh   <= sh;
                r_rs   <= 12'(d) - 12'(sh);
                r_ec   <= (hi_acc ? r_a_e : r_t_e) - $signed({6'b0, sh});
            end
            // Signed magnitude add with the shifted-out bits jammed into the LSB.
            S_ADD: begin
                hi_v = 96'(r_hi_m) << r_sh;
                lo_t = {r_lo_m, 64'b0} >> r_rs[5:0];
                if (r_rs[11:6] != '0) begin
                    lo_v = {95'b0, |r_lo_m};
                end else begin
                    lo_v = 96'(lo_t[107:64]) | {95'b0, |lo_t[63:0]};
                end
                if (r_hi_s == r_lo_s) begin
                    sum   = hi_v + lo_v;
                    sum_s = r_hi_s;
                end else if (hi_v >= lo_v) begin
                    sum   = hi_v - lo_v;
                    sum_s = r_hi_s;
                end else begin
                    sum   = lo_v - hi_v;
                    sum_s = r_lo_s;
                end
                r_m <= sum;
                r_e <= r_ec;
                r_s <= (sum == '0) ? 1'b0 : sum_s;
            end
            default: begin
            end
        endcase
    end

    assign o_rsp.busy = (r_state != S_IDLE);
    assign o_rsp.emit = (r_state == S_RND) && r_last && !i_cmd.out_busy;
    assign o_rsp.sum  = r_fixed ? r_fixed_bits : w_round;

endmodule

[src/iq4nl_q8_row_dot_core.sv]
// Top level of the IQ4_NL by Q8 row dot-product block.
// A row sum is registered with o_out_valid when the unit finishes the last block of a row.
// The unit takes a new item only after it has stepped through the previous one.
// The input is stalled while an item is in the unit; a finished row that meets a stalled
// result holds the unit, and with it the input, until that result is taken.
// Synchronous active-low reset clears the codebook, the row accumulator and all handshakes.
module iq4nl_q8_row_dot_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [63:0] i_codes_first_half,
    input  logic [63:0] i_codes_second_half,
    input  logic [63:0] i_acts_0_7,
    input  logic [63:0] i_acts_8_15,
    input  logic [63:0] i_acts_16_23,
    input  logic [63:0] i_acts_24_31,
    input  logic [15:0] i_weight_scale,
    input  logic [31:0] i_act_scale,
    input  logic        i_last_block,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_row_sum
);

    logic [63:0]       r_cb_low;
    logic [63:0]       r_cb_high;
    logic              r_out_valid;
    logic [31:0]       r_row_sum;
    logic signed [iq4_pkg::DOT_W-1:0] r_dot;

    logic              w_accept;
    logic [127:0]      w_codebook;
    logic signed [iq4_pkg::LANE_SUM_W-1:0] w_lane [iq4_pkg::LANES];
    iq4_pkg::t_fpu_cmd w_cmd;
    iq4_pkg::t_fpu_rsp w_rsp;

    assign w_codebook = {r_cb_high, r_cb_low};
    assign w_accept   = i_in_valid && !w_rsp.busy;
    assign o_in_stall = w_rsp.busy;

    // Codebook registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cb_low  <= '0;
            r_cb_high <= '0;
        end else if (i_cfg_we) begin
            case (iq4_pkg::t_cfg_idx'(i_cfg_idx))
                iq4_pkg::CFG_CODEBOOK_LOW:  r_cb_low  <= i_cfg_data;
                iq4_pkg::CFG_CODEBOOK_HIGH: r_cb_high <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Four lanes: low nibbles give elements 0 to 15, high nibbles 16 to 31.
    iq4_lane u_lane0 (
        .i_clk(i_clk), .i_load(w_accept), .i_high_nib(1'b0),
        .i_codes(i_codes_first_half), .i_acts(i_acts_0_7),
        .i_codebook(w_codebook), .o_sum(w_lane[0])
    );
    iq4_lane u_lane1 (
        .i_clk(i_clk), .i_load(w_accept), .i_high_nib(1'b0),
        .i_codes(i_codes_second_half), .i_acts(i_acts_8_15),
        .i_codebook(w_codebook), .o_sum(w_lane[1])
    );
    iq4_lane u_lane2 (
        .i_clk(i_clk), .i_load(w_accept), .i_high_nib(1'b1),
        .i_codes(i_codes_first_half), .i_acts(i_acts_16_23),
        .i_codebook(w_codebook), .o_sum(w_lane[2])
    );
    iq4_lane u_lane3 (
        .i_clk(i_clk), .i_load(w_accept), .i_high_nib(1'b1),
        .i_codes(i_codes_second_half), .i_acts(i_acts_24_31),
        .i_codebook(w_codebook), .o_sum(w_lane[3])
    );

    // Merge the lane sums into the exact block dot product.
    always_ff @(posedge i_clk) begin
        r_dot <= iq4_pkg::DOT_W'(w_lane[0]) + iq4_pkg::DOT_W'(w_lane[1]) +
                 iq4_pkg::DOT_W'(w_lane[2]) + iq4_pkg::DOT_W'(w_lane[3]);
    end

    assign w_cmd.start    = w_accept;
    assign w_cmd.last     = i_last_block;
    assign w_cmd.out_busy = r_out_valid && i_out_stall;

    iq4_fpu u_fpu (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd),
        .i_weight_scale(i_weight_scale), .i_act_scale(i_act_scale),
        .i_dot(r_dot), .o_rsp(w_rsp)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_rsp.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rsp.emit) begin
            r_row_sum <= w_rsp.sum;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_row_sum   = r_row_sum;

    // A finished row never overwrites a result that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.emit |-> !(r_out_valid && i_out_stall))
        else $error("row sum overwrote a waiting result");

    // An accepted item starts the floating-point unit.
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> w_rsp.busy)
        else $error("accepted item did not start the unit");

    // Any NaN leaving the block is the canonical quiet pattern.
    a_canon_nan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_row_sum[30:23] == 8'hFF && o_row_sum[22:0] != 23'h0)
        |-> (o_row_sum == iq4_pkg::CANON_NAN))
        else $error("non-canonical NaN emitted");

endmodule

[dv/testbench.sv]
// Self-checking testbench for the IQ4_NL by Q8 row dot-product core.
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE       = 12;
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_REPORTED = 10;

    // One weight block with its activations and scales.
    typedef struct {
        logic [63:0] codes_lo;
        logic [63:0] codes_hi;
        logic [63:0] acts [4];
        logic [15:0] w_scale;
        logic [31:0] a_scale;
        logic        last;
    } t_block;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = iq4_pkg::CFG_CODEBOOK_LOW;
    logic [63:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [63:0] i_codes_first_half = '0;
    logic [63:0] i_codes_second_half = '0;
    logic [63:0] i_acts_0_7 = '0;
    logic [63:0] i_acts_8_15 = '0;
    logic [63:0] i_acts_16_23 = '0;
    logic [63:0] i_acts_24_31 = '0;
    logic [15:0] i_weight_scale = '0;
    logic [31:0] i_act_scale = '0;
    logic        i_last_block = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [31:0] o_row_sum;

    // Predictor state: codebook copy and the running row sum.
    logic [63:0] cb_low = '0;
    logic [63:0] cb_high = '0;
    logic [31:0] row_sum_acc = '0;
    logic [31:0] expected_sums [$];

    int  mismatches = 0;
    int  cycles = 0;
    bit  tx_idle_en = 1'b1;
    bit  rx_idle_en = 1'b1;
    logic hold_req = 1'b0;
    bit  hold_armed = 1'b0;
    int  hold_left = 0;

    iq4nl_q8_row_dot_core u_top (.*);

    // Clock, 2 ns period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_req && !hold_armed) begin
            hold_armed  <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            if (!hold_req) hold_armed <= 1'b0;
            i_out_stall <= rx_idle_en && ($urandom_range(99) < 24);
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        logic [31:0] want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_sums.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTED)
                    $display("unexpected row sum %h", o_row_sum);
            end else begin
                want = expected_sums.pop_front();
                if (want !== o_row_sum) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTED)
                        $display("row_sum mismatch: expected %h actual %h", want, o_row_sum);
                end
            end
        end
    end

    // Widen a binary32 pattern to a real exactly.
    function automatic real f32_to_real(input logic [31:0] f);
        logic [63:0] d;
        logic [22:0] m;
        int          sh;
        m = f[22:0];
        sh = 0;
        if (f[30:23] == 8'hFF) begin
            d = {f[31], 11'h7FF, m, 29'b0};
        end else if (f[30:23] == 8'h00) begin
            if (m == 0) begin
                d = {f[31], 63'b0};
            end else begin
                while (!m[22]) begin
                    m = m << 1;
                    sh++;
                end
                d = {f[31], 11'(1023 - 127 - sh), m[21:0], 30'b0};
            end
        end else begin
            d = {f[31], 11'(int'(f[30:23]) - 127 + 1023), m, 29'b0};
        end
        return $bitstoreal(d);
    endfunction

    // Half-precision pattern to single-precision pattern.
    function automatic logic [31:0] half_to_f32(input logic [15:0] h);
        logic [9:0] m;
        int         e2;
        m = h[9:0];
        if (h[14:10] == 5'h1F) return {h[15], 8'hFF, m, 13'b0};
        if (h[14:10] == 5'h00) begin
            if (m == 0) return {h[15], 31'b0};
            e2 = 113;
            while (!m[9]) begin
                m = m << 1;
                e2--;
            end
            e2--;
            return {h[15], 8'(e2), m[8:0], 14'b0};
        end
        return {h[15], 8'(int'(h[14:10]) + 112), m, 13'b0};
    endfunction

    // Round a real to binary32 (nearest even), NaN made canonical.
    function automatic logic [31:0] real_to_f32(input real x);
        logic [63:0] d, sig, kept, rem, half;
        int          ex, sh;
        d = $realtobits(x);
        if (d[62:52] == 11'h7FF)
            return (d[51:0] != 0) ? iq4_pkg::CANON_NAN : {d[63], 8'hFF, 23'b0};
        if (d[62:52] == 11'h000) return {d[63], 31'b0};
        ex = int'(d[62:52]) - 1023;
        if (ex > 128) return {d[63], 8'hFF, 23'b0};
        sig = {11'b0, 1'b1, d[51:0]};
        sh = (ex >= -126) ? 29 : 29 + (-126 - ex);
        if (sh > 60) return {d[63], 31'b0};
        kept = sig >> sh;
        rem  = sig & ((64'd1 << sh) - 1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && kept[0])) kept++;
        if (ex >= -126) begin
            if (kept[24]) begin
                kept = kept >> 1;
                ex++;
            end
            if (ex > 127) return {d[63], 8'hFF, 23'b0};
            return {d[63], 8'(ex + 127), kept[22:0]};
        end
        return {d[63], kept[30:0]};
    endfunction

    // Sum in double precision with round-to-odd, so a later single rounding is exact.
    function automatic real sum_to_odd(input real p, input real c);
        real         s, cb, err;
        logic [63:0] sb;
        s  = p + c;
        sb = $realtobits(s);
        if (sb[62:52] == 11'h7FF) return s;
        cb  = s - p;
        err = (p - (s - cb)) + (c - cb);
        if (err != 0.0 && !sb[0]) begin
            if ((err > 0.0) == (s > 0.0)) sb++;
            else sb--;
        end
        return $bitstoreal(sb);
    endfunction

    function automatic int codebook_value(input logic [3:0] code);
        logic [63:0] w;
        w = code[3] ? cb_high : cb_low;
        return int'($signed(w[code[2:0]*8 +: 8]));
    endfunction

    function automatic int act_value(input t_block b, input int j);
        return int'($signed(b.acts[j / 8][(j % 8)*8 +: 8]));
    endfunction

    // Advance the predicted row sum by one block; queue the sum on the last block.
    task automatic predict_block(input t_block b);
        int          dot;
        logic [7:0]  q;
        logic [31:0] scale;
        real         term;
        dot = 0;
        for (int k = 0; k < 16; k++) begin
            q = (k < 8) ? b.codes_lo[k*8 +: 8] : b.codes_hi[(k-8)*8 +: 8];
            dot += codebook_value(q[3:0]) * act_value(b, k);
            dot += codebook_value(q[7:4]) * act_value(b, k + 16);
        end
        scale = real_to_f32(f32_to_real(half_to_f32(b.w_scale)) * f32_to_real(b.a_scale));
        term  = real'(dot) * f32_to_real(scale);
        row_sum_acc = real_to_f32(sum_to_odd(term, f32_to_real(row_sum_acc)));
        if (b.last) begin
            expected_sums.push_back(row_sum_acc);
            row_sum_acc = '0;
        end
    endtask

    // Offer one item, wait for it to be taken, then maybe idle.
    task automatic send_block(input t_block b);
        int gap;
        i_in_valid          <= 1'b1;
        i_codes_first_half  <= b.codes_lo;
        i_codes_second_half <= b.codes_hi;
        i_acts_0_7          <= b.acts[0];
        i_acts_8_15         <= b.acts[1];
        i_acts_16_23        <= b.acts[2];
        i_acts_24_31        <= b.acts[3];
        i_weight_scale      <= b.w_scale;
        i_act_scale         <= b.a_scale;
        i_last_block        <= b.last;
        do @(posedge i_clk); while (o_in_stall);
        predict_block(b);
        if (tx_idle_en && $urandom_range(99) < 24) begin
            i_in_valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop offering and wait until every expected row sum has come back.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_sums.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_codebook(input logic [63:0] lo, input logic [63:0] hi);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= iq4_pkg::CFG_CODEBOOK_LOW;
        i_cfg_data <= lo;
        @(posedge i_clk);
        i_cfg_idx  <= iq4_pkg::CFG_CODEBOOK_HIGH;
        i_cfg_data <= hi;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cb_low  = lo;
        cb_high = hi;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Random block; tame scales keep rows finite, wild ones are raw bit patterns.
    function automatic t_block random_block(input logic last, input bit wild);
        t_block b;
        b.codes_lo = rand64();
        b.codes_hi = rand64();
        for (int i = 0; i < 4; i++) b.acts[i] = rand64();
        if (wild) begin
            b.w_scale = 16'($urandom());
            b.a_scale = $urandom();
        end else begin
            b.w_scale = {1'($urandom()), 5'($urandom_range(4, 20)), 10'($urandom())};
            b.a_scale = {1'($urandom()), 8'($urandom_range(100, 140)), 23'($urandom())};
        end
        b.last = last;
        return b;
    endfunction

    function automatic t_block fixed_block(input logic [63:0] codes, input logic [63:0] acts,
                                           input logic [15:0] ws, input logic [31:0] as,
                                           input logic last);
        t_block b;
        b.codes_lo = codes;
        b.codes_hi = codes;
        for (int i = 0; i < 4; i++) b.acts[i] = acts;
        b.w_scale = ws;
        b.a_scale = as;
        b.last    = last;
        return b;
    endfunction

    // Random rows of one to eight blocks.
    task automatic send_random_rows(input int n_blocks, input int wild_pct);
        int left, len;
        left = n_blocks;
        while (left > 0) begin
            len = $urandom_range(1, 8);
            if (len > left) len = left;
            for (int i = 0; i < len; i++)
                send_block(random_block(i == len - 1, $urandom_range(99) < wild_pct));
            left -= len;
        end
    endtask

    // With the codebook at reset every dot product is zero.
    task automatic test_reset_codebook();
        send_random_rows(3, 0);
        drain();
    endtask

    // Field extremes, special scales, overflow and NaN rows.
    task automatic test_directed();
        write_codebook(64'hF6EA_DDCF_BFAE_9881, 64'h7159_4535_261A_0D01);
        send_block(fixed_block('1, 64'h8080_8080_8080_8080, 16'h3C00, 32'h3F80_0000, 1'b1));
        send_block(fixed_block('0, 64'h7F7F_7F7F_7F7F_7F7F, 16'hBC00, 32'h3F80_0000, 1'b1));
        send_block(fixed_block(64'h0F1E_2D3C_4B5A_6978, 64'h0102_0304_FFFE_FDFC,
                               16'h0001, 32'h0000_0001, 1'b1));
        send_block(fixed_block('1, 64'h8080_8080_8080_8080, 16'h7BFF, 32'h7F7F_FFFF, 1'b1));
        send_block(fixed_block('1, 64'h7F7F_7F7F_7F7F_7F7F, 16'h7C00, 32'h3F80_0000, 1'b0));
        send_block(fixed_block('1, 64'h8181_8181_8181_8181, 16'h7C00, 32'h3F80_0000, 1'b1));
        send_block(fixed_block('1, 64'h7F7F_7F7F_7F7F_7F7F, 16'h7E00, 32'h3F80_0000, 1'b1));
        send_block(fixed_block('1, 64'h7F7F_7F7F_7F7F_7F7F, 16'h3C00, 32'h7FC0_0001, 1'b1));
        send_block(fixed_block('1, 64'h7F7F_7F7F_7F7F_7F7F, 16'h0000, 32'h7F80_0000, 1'b1));
        send_block(fixed_block('1, 64'h0101_0101_0101_0101, 16'h8000, 32'h0000_0000, 1'b1));
        send_block(fixed_block(64'h8877_6655_4433_2211, 64'h0180_7F02_FE03_FD04,
                               16'h3555, 32'h3EAA_AAAB, 1'b0));
        send_block(fixed_block(64'h1122_3344_5566_7788, 64'hFF01_FF01_FF01_FF01,
                               16'h2E66, 32'hC2C8_0000, 1'b0));
        send_block(fixed_block(64'h1122_3344_5566_7788, 64'h0180_7F02_FE03_FD04,
                               16'h3555, 32'h3EAA_AAAB, 1'b1));
        send_block(fixed_block('0, 64'h0000_0000_0000_0000, 16'hFFFF, 32'hFFFF_FFFF, 1'b1));
        drain();
        write_codebook(64'h8080_8080_8080_8080, 64'h8080_8080_8080_8080);
        send_block(fixed_block('1, 64'h8080_8080_8080_8080, 16'h3C00, 32'h3F80_0000, 1'b1));
        send_block(fixed_block(64'h5A5A_5A5A_5A5A_5A5A, 64'h7F80_7F80_7F80_7F80,
                               16'h0400, 32'h0080_0000, 1'b1));
        drain();
        write_codebook(64'h7F7F_7F7F_7F7F_7F7F, 64'h7F7F_7F7F_7F7F_7F7F);
        send_block(fixed_block('1, 64'h7F7F_7F7F_7F7F_7F7F, 16'h3C00, 32'h3F80_0000, 1'b1));
        send_block(fixed_block('1, 64'h8080_8080_8080_8080, 16'h0001, 32'h0000_0001, 1'b1));
        drain();
    endtask

    // Receiver holds off for a long stretch while items keep coming.
    task automatic test_output_hold();
        write_codebook(rand64(), rand64());
        tx_idle_en = 1'b0;
        hold_req <= 1'b1;
        for (int i = 0; i < 24; i++) send_block(random_block(1'b1, 1'b0));
        hold_req <= 1'b0;
        tx_idle_en = 1'b1;
        drain();
    endtask

    // Sender pauses until all row sums are back, a few times over.
    task automatic test_sender_pause();
        for (int i = 0; i < 3; i++) begin
            send_random_rows(4, 10);
            drain();
        end
    endtask

    // Long random run over several codebooks, one stretch with no idling.
    task automatic test_random();
        write_codebook(64'hF6EA_DDCF_BFAE_9881, 64'h7159_4535_261A_0D01);
        send_random_rows(300, 5);
        drain();
        write_codebook(rand64(), rand64());
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        send_random_rows(250, 5);
        drain();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        write_codebook(64'h8080_8080_8080_8080, 64'h7F7F_7F7F_7F7F_7F7F);
        send_random_rows(150, 5);
        drain();
        write_codebook(rand64(), rand64());
        send_random_rows(330, 15);
        drain();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_codebook();
        test_directed();
        test_output_hold();
        test_sender_pause();
        test_random();
        if (mismatches == 0 && expected_sums.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
